>>> rtl/wfs_pkg.sv
`timescale 1ns / 1ps

package wfs_pkg;

   // field widths
   localparam int COORD_W    = 16;
   localparam int HEAD_W     = 16;
   localparam int SLOT_W     = 8;
   localparam int STEER_W    = 16;
   localparam int THR_W      = 8;
   localparam int TIDX_W     = 8;

   // register widths
   localparam int LEN_W      = 9;
   localparam int REACH_W    = 16;
   localparam int GAIN_W     = 12;

   // bus widths
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // angle datapath
   localparam int ANGLE_W       = 32;
   localparam int CORDIC_W      = 28;
   localparam int ATAN_TAB_SIZE = 24;
   localparam int ATAN_IDX_W    = 5;

   // shared multiplier and accumulator
   localparam int MUL_A_W = 24;
   localparam int MUL_B_W = 18;
   localparam int PROD_W  = 42;
   localparam int ACC_W   = 64;
   localparam int P1_W    = 43;

   // pi in Q16, rounding bias and final scaling of the steering product
   localparam logic [MUL_B_W-1:0] PI_Q16      = 18'd205887;
   localparam logic [ACC_W-1:0]   ROUND_BIAS  = 64'h0000_0100_0000_0000;
   localparam logic [ANGLE_W-1:0] HALF_TURN   = 32'h8000_0000;
   localparam logic [STEER_W-1:0] STEER_MAX   = 16'd16384;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_TICK = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      REG_LINE_LENGTH     = 2'd0,
      REG_REACH_DISTANCE  = 2'd1,
      REG_STEERING_GAIN   = 2'd2,
      REG_DRIVE_THROTTLE  = 2'd3
   } reg_idx_type;

   // atan(2^-i) as binary angle, 2^32 is a full turn
   function automatic logic [ANGLE_W-1:0] atan_angle(input logic [ATAN_IDX_W-1:0] i);
      logic [ANGLE_W-1:0] a;
      case (i)
         5'd0:    a = 32'h20000000;
         5'd1:    a = 32'h12E4051E;
         5'd2:    a = 32'h09FB385B;
         5'd3:    a = 32'h051111D4;
         5'd4:    a = 32'h028B0D43;
         5'd5:    a = 32'h0145D7E1;
         5'd6:    a = 32'h00A2F61E;
         5'd7:    a = 32'h00517C55;
         5'd8:    a = 32'h0028BE53;
         5'd9:    a = 32'h00145F2F;
         5'd10:   a = 32'h000A2F98;
         5'd11:   a = 32'h000517CC;
         5'd12:   a = 32'h00028BE6;
         5'd13:   a = 32'h000145F3;
         5'd14:   a = 32'h0000A2FA;
         5'd15:   a = 32'h0000517D;
         5'd16:   a = 32'h000028BE;
         5'd17:   a = 32'h0000145F;
         5'd18:   a = 32'h00000A30;
         5'd19:   a = 32'h00000518;
         5'd20:   a = 32'h0000028C;
         5'd21:   a = 32'h00000146;
         5'd22:   a = 32'h000000A3;
         5'd23:   a = 32'h00000051;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

>>> rtl/wfs_ram.sv
`timescale 1ns / 1ps

module wfs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/waypoint_follow_steering_top.sv
`timescale 1ns / 1ps

// Waypoint-following proportional steering.
// req_ channel: one word per command. tuser = cmd. A load word (cmd 0) writes
// one waypoint into the table and gives no result; the block stays ready for
// the next word. A tick word (cmd 1) carries the car pose and returns one
// rsp_ word with steering, throttle and target index, or none while
// line_length is zero.
// A tick runs through one shared 24x18 multiplier with accumulator (distance
// test and gain scaling, each partial product through ST_MUL then ST_ACC), a
// single waypoint memory read port (two reads) and an iterative CORDIC stage,
// one micro-rotation per cycle. A new tick is taken only after the result word
// of the last one is loaded; req_tready is low while a tick is in flight.
// The result sits in an output register; if rsp_tready is held low the block
// waits with the next result until the register is free.
// Reset clears the registers to their defaults (line_length 0, reach 40,
// gain 2.0, throttle 0.7), the target index to 0 and drops any pending result.
// The waypoint table is not cleared: load every slot used before ticking.
module waypoint_follow_steering_top #(
   parameter int MAX_WAYPOINTS    = 256,
   parameter int ANGLE_ITERATIONS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // wp_index[7:0], wp_x[23:8], wp_y[39:24], car_x[55:40], car_y[71:56],
   // car_heading[87:72]
   input  logic [wfs_pkg::REQ_DATA_W-1:0]  req_tdata,
   // cmd[0]
   input  logic                            req_tuser,
   // response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // steering[15:0], throttle[23:16], target_index[31:24]
   output logic [wfs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [wfs_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [wfs_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [wfs_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   import wfs_pkg::*;

   localparam int IW   = $clog2(MAX_WAYPOINTS);
   localparam int LENW = $clog2(MAX_WAYPOINTS + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ_A,
      ST_DIFF_A,
      ST_MUL,
      ST_ACC,
      ST_DECIDE,
      ST_READ_B,
      ST_DIFF_B,
      ST_CORDIC,
      ST_ANGLE,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      OP_DX2,
      OP_DY2,
      OP_REACH2,
      OP_MAG_LO,
      OP_MAG_HI,
      OP_PROD_LO,
      OP_PROD_HI
   } op_type;

   // configuration registers
   logic [LEN_W-1:0]   line_length_ff;
   logic [REACH_W-1:0] reach_distance_ff;
   logic [GAIN_W-1:0]  steering_gain_ff;
   logic [THR_W-1:0]   drive_throttle_ff;

   // sequencer and datapath registers
   state_type                 state_ff;
   op_type                    op_ff;
   logic [IW-1:0]             target_ff;
   logic [LENW-1:0]           len_ff;
   logic [COORD_W-1:0]        cx_ff;
   logic [COORD_W-1:0]        cy_ff;
   logic [HEAD_W-1:0]         hd_ff;
   logic [COORD_W-1:0]        ax_ff;
   logic [COORD_W-1:0]        ay_ff;
   logic [PROD_W-1:0]         prod_ff;
   logic [ACC_W-1:0]          acc_ff;
   logic [P1_W-1:0]           p1_ff;
   logic [ANGLE_W-1:0]        mag_ff;
   logic                      neg_ff;
   logic signed [CORDIC_W-1:0] x_ff;
   logic signed [CORDIC_W-1:0] y_ff;
   logic [ANGLE_W-1:0]        z_ff;
   logic                      zero_ff;
   logic [ATAN_IDX_W-1:0]     iter_ff;
   logic                      rsp_tvalid_ff;
   logic [RSP_DATA_W-1:0]     rsp_tdata_ff;

   // request fields
   logic [SLOT_W-1:0]  wp_index;
   logic [COORD_W-1:0] wp_x;
   logic [COORD_W-1:0] wp_y;
   logic [COORD_W-1:0] car_x;
   logic [COORD_W-1:0] car_y;
   logic [HEAD_W-1:0]  car_heading;
   cmd_type            cmd;

   assign wp_index    = req_tdata[7:0];
   assign wp_x        = req_tdata[23:8];
   assign wp_y        = req_tdata[39:24];
   assign car_x       = req_tdata[55:40];
   assign car_y       = req_tdata[71:56];
   assign car_heading = req_tdata[87:72];
   assign cmd         = cmd_type'(req_tuser);

   logic req_accept;
   logic rsp_free;
   logic csr_wr;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff     <= LEN_W'(0);
         reach_distance_ff  <= REACH_W'(40);
         steering_gain_ff   <= GAIN_W'(512);
         drive_throttle_ff  <= THR_W'(179);
      end else if (csr_wr) begin
         case (reg_idx_type'(csr_paddr[3:2]))
            REG_LINE_LENGTH:     line_length_ff     <= csr_pwdata[LEN_W-1:0];
            REG_REACH_DISTANCE:  reach_distance_ff  <= csr_pwdata[REACH_W-1:0];
            REG_STEERING_GAIN:   steering_gain_ff   <= csr_pwdata[GAIN_W-1:0];
            REG_DRIVE_THROTTLE:  drive_throttle_ff  <= csr_pwdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      case (reg_idx_type'(csr_paddr[3:2]))
         REG_LINE_LENGTH:     csr_prdata = CSR_DATA_W'(line_length_ff);
         REG_REACH_DISTANCE:  csr_prdata = CSR_DATA_W'(reach_distance_ff);
         REG_STEERING_GAIN:   csr_prdata = CSR_DATA_W'(steering_gain_ff);
         REG_DRIVE_THROTTLE:  csr_prdata = CSR_DATA_W'(drive_throttle_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // effective line length, limited to the table depth
   logic [LENW-1:0] len_c;
   logic            stale_c;

   assign len_c   = (32'(line_length_ff) > MAX_WAYPOINTS) ? LENW'(MAX_WAYPOINTS)
                                                          : LENW'(line_length_ff);
   assign stale_c = (LENW'(target_ff) >= len_c);

   // waypoint table, {y, x} per slot
   logic                     wr_en;
   logic [2*COORD_W-1:0]     wp_rd;

   assign wr_en = req_accept && (cmd == CMD_LOAD) && (32'(wp_index) < MAX_WAYPOINTS);

   wfs_ram #(
      .WIDTH (2 * COORD_W),
      .DEPTH (MAX_WAYPOINTS)
   ) u_wp_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IW'(wp_index)),
      .wr_data ({wp_y, wp_x}),
      .rd_addr (target_ff),
      .rd_data (wp_rd)
   );

   // offset from car to the waypoint just read
   logic signed [COORD_W:0] dx_c;
   logic signed [COORD_W:0] dy_c;
   logic        [COORD_W:0] dx_neg;
   logic        [COORD_W:0] dy_neg;
   logic [COORD_W-1:0]      ax_c;
   logic [COORD_W-1:0]      ay_c;

   assign dx_c   = $signed({wp_rd[COORD_W-1], wp_rd[COORD_W-1:0]})
                 - $signed({cx_ff[COORD_W-1], cx_ff});
   assign dy_c   = $signed({wp_rd[2*COORD_W-1], wp_rd[2*COORD_W-1:COORD_W]})
                 - $signed({cy_ff[COORD_W-1], cy_ff});
   assign dx_neg = -dx_c;
   assign dy_neg = -dy_c;
   assign ax_c   = dx_c[COORD_W] ? dx_neg[COORD_W-1:0] : dx_c[COORD_W-1:0];
   assign ay_c   = dy_c[COORD_W] ? dy_neg[COORD_W-1:0] : dy_c[COORD_W-1:0];

   // shared multiplier operand select
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [PROD_W-1:0]  prod_in;

   always_comb begin
      case (op_ff)
         OP_DX2: begin
            mul_a = MUL_A_W'(ax_ff);
            mul_b = MUL_B_W'(ax_ff);
         end
         OP_DY2: begin
            mul_a = MUL_A_W'(ay_ff);
            mul_b = MUL_B_W'(ay_ff);
         end
         OP_REACH2: begin
            mul_a = MUL_A_W'(reach_distance_ff);
            mul_b = MUL_B_W'(reach_distance_ff);
         end
         OP_MAG_LO: begin
            mul_a = MUL_A_W'(mag_ff[15:0]);
            mul_b = MUL_B_W'(steering_gain_ff);
         end
         OP_MAG_HI: begin
            mul_a = MUL_A_W'(mag_ff[31:16]);
            mul_b = MUL_B_W'(steering_gain_ff);
         end
         OP_PROD_LO: begin
            mul_a = MUL_A_W'(p1_ff[21:0]);
            mul_b = PI_Q16;
         end
         OP_PROD_HI: begin
            mul_a = MUL_A_W'(p1_ff[42:22]);
            mul_b = PI_Q16;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   // accumulate the registered product at its weight
   logic [ACC_W-1:0] term_c;
   logic [ACC_W-1:0] acc_in;

   always_comb begin
      case (op_ff)
         OP_MAG_HI:  term_c = ACC_W'(prod_ff) << 16;
         OP_PROD_HI: term_c = ACC_W'(prod_ff) << 22;
         default:    term_c = ACC_W'(prod_ff);
      endcase
   end

   assign acc_in = (op_ff == OP_REACH2) ? (acc_ff - term_c) : (acc_ff + term_c);

   // next target index after a reached waypoint
   logic [LENW-1:0] next_idx_c;

   assign next_idx_c = LENW'(target_ff) + LENW'(1);

   // cordic start vector, scaled by 256
   logic signed [CORDIC_W-1:0] x_init;
   logic signed [CORDIC_W-1:0] y_init;

   assign x_init = CORDIC_W'($signed({dx_c, 8'd0}));
   assign y_init = CORDIC_W'($signed({dy_c, 8'd0}));

   // one vectoring micro-rotation
   logic signed [CORDIC_W-1:0] xs_c;
   logic signed [CORDIC_W-1:0] ys_c;
   logic signed [CORDIC_W-1:0] x_in;
   logic signed [CORDIC_W-1:0] y_in;
   logic        [ANGLE_W-1:0]  z_in;

   assign xs_c = x_ff >>> iter_ff;
   assign ys_c = y_ff >>> iter_ff;

   always_comb begin
      if (y_ff > 0) begin
         x_in = x_ff + ys_c;
         y_in = y_ff - xs_c;
         z_in = z_ff + atan_angle(iter_ff);
      end else begin
         x_in = x_ff - ys_c;
         y_in = y_ff + xs_c;
         z_in = z_ff - atan_angle(iter_ff);
      end
   end

   // heading error, wraps naturally in 32-bit binary angle
   logic [ANGLE_W-1:0] d_c;
   logic [ANGLE_W-1:0] d_neg;

   assign d_c   = (zero_ff ? '0 : z_ff) - {hd_ff, 16'd0};
   assign d_neg = -d_c;

   // scaled magnitude, saturated, signed
   logic [20:0]        s_c;
   logic [STEER_W-1:0] sat_c;
   logic [STEER_W-1:0] steer_c;

   assign s_c     = acc_ff[61:41];
   assign sat_c   = (s_c > 21'(STEER_MAX)) ? STEER_MAX : s_c[STEER_W-1:0];
   assign steer_c = neg_ff ? (-sat_c) : sat_c;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= OP_DX2;
         target_ff     <= '0;
         iter_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // the output state loads or holds the word itself
         if (rsp_tready && (state_ff != ST_OUT)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept && (cmd == CMD_TICK) && (len_c != '0)) begin
                  cx_ff  <= car_x;
                  cy_ff  <= car_y;
                  hd_ff  <= car_heading;
                  len_ff <= len_c;
                  if (stale_c) begin
                     target_ff <= '0;
                  end
                  state_ff <= ST_READ_A;
               end
            end
            ST_READ_A: begin
               state_ff <= ST_DIFF_A;
            end
            ST_DIFF_A: begin
               ax_ff    <= ax_c;
               ay_ff    <= ay_c;
               acc_ff   <= '0;
               op_ff    <= OP_DX2;
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               // the gain product restarts the sum at the rounding bias
               acc_ff <= (op_ff == OP_MAG_HI) ? ROUND_BIAS : acc_in;
               case (op_ff)
                  OP_DX2: begin
                     op_ff    <= OP_DY2;
                     state_ff <= ST_MUL;
                  end
                  OP_DY2: begin
                     op_ff    <= OP_REACH2;
                     state_ff <= ST_MUL;
                  end
                  OP_REACH2: begin
                     state_ff <= ST_DECIDE;
                  end
                  OP_MAG_LO: begin
                     op_ff    <= OP_MAG_HI;
                     state_ff <= ST_MUL;
                  end
                  OP_MAG_HI: begin
                     p1_ff    <= acc_in[P1_W-1:0];
                     op_ff    <= OP_PROD_LO;
                     state_ff <= ST_MUL;
                  end
                  OP_PROD_LO: begin
                     op_ff    <= OP_PROD_HI;
                     state_ff <= ST_MUL;
                  end
                  OP_PROD_HI: begin
                     state_ff <= ST_OUT;
                  end
                  default: begin
                     state_ff <= ST_IDLE;
                  end
               endcase
            end
            ST_DECIDE: begin
               // squared distance below squared reach: step to the next waypoint
               if (acc_ff[ACC_W-1]) begin
                  target_ff <= (next_idx_c == len_ff) ? '0 : IW'(next_idx_c);
               end
               state_ff <= ST_READ_B;
            end
            ST_READ_B: begin
               state_ff <= ST_DIFF_B;
            end
            ST_DIFF_B: begin
               // pre-rotate by half a turn for targets behind
               if (dx_c[COORD_W]) begin
                  x_ff <= -x_init;
                  y_ff <= -y_init;
                  z_ff <= HALF_TURN;
               end else begin
                  x_ff <= x_init;
                  y_ff <= y_init;
                  z_ff <= '0;
               end
               zero_ff  <= (dx_c == '0) && (dy_c == '0);
               iter_ff  <= '0;
               state_ff <= ST_CORDIC;
            end
            ST_CORDIC: begin
               x_ff <= x_in;
               y_ff <= y_in;
               z_ff <= z_in;
               if (iter_ff == ATAN_IDX_W'(ANGLE_ITERATIONS - 1)) begin
                  state_ff <= ST_ANGLE;
               end else begin
                  iter_ff <= iter_ff + ATAN_IDX_W'(1);
               end
            end
            ST_ANGLE: begin
               neg_ff   <= d_c[ANGLE_W-1];
               mag_ff   <= d_c[ANGLE_W-1] ? d_neg : d_c;
               acc_ff   <= '0;
               op_ff    <= OP_MAG_LO;
               state_ff <= ST_MUL;
            end
            ST_OUT: begin
               if (rsp_free) begin
                  rsp_tdata_ff  <= {TIDX_W'(target_ff), drive_throttle_ff, steer_c};
                  rsp_tvalid_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // a finished result waits while the output register is still occupied
   a_out_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) && rsp_tvalid_ff && !rsp_tready |=> (state_ff == ST_OUT))
      else $error("result left the sequencer while the output was occupied");

   // steering stays within plus or minus one
   a_steer_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> ($signed(rsp_tdata_ff[STEER_W-1:0]) <= $signed(STEER_MAX))
                     && ($signed(rsp_tdata_ff[STEER_W-1:0]) >= -$signed(STEER_MAX)))
      else $error("steering outside saturation range");

   // target index stays inside the line after the update
   a_target_in_line: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) |=> (LENW'(target_ff) < len_ff))
      else $error("target index past line length");

   // a load word never starts a tick sequence
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept && (cmd == CMD_LOAD) |=> (state_ff == ST_IDLE))
      else $error("load word started a tick");

   // cordic step count stays within the configured iterations
   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CORDIC) |-> (32'(iter_ff) < ANGLE_ITERATIONS))
      else $error("cordic step count overrun");

endmodule
